// ===== hdl/mlo_pkg.sv =====
// ---------------------------------------------------------------------------
// mlo_pkg: shared types and constants for the mouse-look orientation block
// Field widths, angle format, CORDIC table and queue entry type.
// ---------------------------------------------------------------------------
package mlo_pkg;

    localparam int DELTA_W       = 16;
    localparam int SENS_W        = 16;
    localparam int SENS_FRAC     = 8;
    localparam logic [SENS_W-1:0] SENS_RESET = 16'd256;

    localparam int ANGLE_BITS    = 16;
    localparam int OUT_FRAC_BITS = 15;
    localparam int OUT_W         = 16;

    // delta * sensitivity, rounding add, then fraction bits dropped
    localparam int PROD_IN_W     = DELTA_W + SENS_W + 1;
    localparam int INC_W         = PROD_IN_W + 1 - SENS_FRAC;
    localparam int PSUM_W        = INC_W + 1;

    localparam int TURN_W        = 32;
    localparam int CORDIC_W      = 32;
    localparam int CORDIC_STEPS  = 30;
    localparam int ITER_W        = 5;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

    localparam int PROD_W        = 2 * CORDIC_W;
    localparam int QSHIFT        = 2 * (CORDIC_W - 2) - OUT_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sd1 <<< (QSHIFT - 1);
    localparam logic signed [PROD_W-1:0] Q_MAX = (64'sd1 <<< OUT_FRAC_BITS) - 64'sd1;
    localparam logic signed [PROD_W-1:0] Q_MIN = -(64'sd1 <<< OUT_FRAC_BITS);

    localparam int QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic [ANGLE_BITS-1:0]        yaw;
        logic signed [ANGLE_BITS-1:0] pitch;
    } angle_pair_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // arctangent of 2^-i, 2^32 units per turn
    function automatic logic signed [TURN_W-1:0] atan_turn(input logic [ITER_W-1:0] idx);
        logic signed [TURN_W-1:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            5'd24:   val = 32'h00000029;
            5'd25:   val = 32'h00000014;
            5'd26:   val = 32'h0000000A;
            5'd27:   val = 32'h00000005;
            5'd28:   val = 32'h00000003;
            5'd29:   val = 32'h00000001;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== hdl/mlo_front.sv =====
// ---------------------------------------------------------------------------
// mlo_front: delta intake and head angle update
// Scales each mouse delta by the sensitivity, wraps yaw, clamps pitch and
// pushes the new angle pair into the queue.
// ---------------------------------------------------------------------------
module mlo_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mlo_pkg::SENS_W-1:0]      cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [2*mlo_pkg::DELTA_W-1:0]   s_tdata,
    output logic                            push,
    output mlo_pkg::angle_pair_t            push_data,
    input  mlo_pkg::queue_stat_t            q_stat
);

    localparam int AB = mlo_pkg::ANGLE_BITS;
    localparam int PW = mlo_pkg::PSUM_W;
    localparam logic signed [PW-1:0] QUARTER = PW'(1) <<< (AB - 2);

    typedef enum logic [2:0]
    {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_UPD  = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [mlo_pkg::SENS_W-1:0]                sens_reg;
    logic signed [mlo_pkg::DELTA_W-1:0]        dx_reg, dy_reg;
    logic signed [mlo_pkg::PROD_IN_W-1:0]      px_reg, py_reg;
    logic [AB-1:0]                             yaw_reg, yaw_next;
    logic signed [AB-1:0]                      pitch_reg, pitch_next;

    logic signed [mlo_pkg::SENS_W:0]           sens_s;
    logic signed [mlo_pkg::PROD_IN_W:0]        rx, ry;
    logic signed [mlo_pkg::INC_W-1:0]          inc_x, inc_y;
    logic signed [PW-1:0]                      psum;
    logic                                      accept;

    assign s_tready = (state_reg == F_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign sens_s   = signed'({1'b0, sens_reg});
    assign push     = (state_reg == F_UPD) && !q_stat.full;

    // round to nearest, ties up, then drop the fraction bits
    always_comb
    begin
        rx    = {px_reg[mlo_pkg::PROD_IN_W-1], px_reg} + (mlo_pkg::PROD_IN_W+1)'(128);
        ry    = {py_reg[mlo_pkg::PROD_IN_W-1], py_reg} + (mlo_pkg::PROD_IN_W+1)'(128);
        inc_x = rx[mlo_pkg::PROD_IN_W:mlo_pkg::SENS_FRAC];
        inc_y = ry[mlo_pkg::PROD_IN_W:mlo_pkg::SENS_FRAC];

        yaw_next = yaw_reg - inc_x[AB-1:0];

        psum = PW'(pitch_reg) + PW'(inc_y);
        if (psum > QUARTER)
        begin
            pitch_next = QUARTER[AB-1:0];
        end
        else if (psum < -QUARTER)
        begin
            pitch_next = -QUARTER[AB-1:0];
        end
        else
        begin
            pitch_next = psum[AB-1:0];
        end
    end

    assign push_data.yaw   = yaw_next;
    assign push_data.pitch = pitch_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_UPD;
            end
            F_UPD:
            begin
                if (!q_stat.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            sens_reg  <= mlo_pkg::SENS_RESET;
            yaw_reg   <= '0;
            pitch_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                sens_reg <= cfg_wr_data;
            end
            if (push)
            begin
                yaw_reg   <= yaw_next;
                pitch_reg <= pitch_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg <= s_tdata[mlo_pkg::DELTA_W-1:0];
            dy_reg <= s_tdata[2*mlo_pkg::DELTA_W-1:mlo_pkg::DELTA_W];
        end
        if (state_reg == F_MUL)
        begin
            px_reg <= dx_reg * sens_s;
            py_reg <= dy_reg * sens_s;
        end
    end

endmodule

// ===== hdl/mlo_queue.sv =====
// ---------------------------------------------------------------------------
// mlo_queue: short angle-pair queue
// Decouples the angle update from the trigonometry back end.
// ---------------------------------------------------------------------------
module mlo_queue
#(
    parameter int DEPTH = mlo_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mlo_pkg::angle_pair_t  push_data,
    input  logic                  pop,
    output mlo_pkg::angle_pair_t  head,
    output mlo_pkg::queue_stat_t  q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mlo_pkg::angle_pair_t mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/mlo_cordic.sv =====
// ---------------------------------------------------------------------------
// mlo_cordic: iterative CORDIC rotator, one micro-rotation per cycle while advance is high
// Reduces the angle to a quadrant plus residual and yields cosine and sine
// with 30 fraction bits.
// ---------------------------------------------------------------------------
module mlo_cordic
(
    input  logic                                  clk,
    input  logic                                  load,
    input  logic                                  advance,
    input  logic [mlo_pkg::ITER_W-1:0]            iter,
    input  logic [mlo_pkg::TURN_W-1:0]            angle,
    output logic signed [mlo_pkg::CORDIC_W-1:0]   cos_val,
    output logic signed [mlo_pkg::CORDIC_W-1:0]   sin_val,
    output logic signed [mlo_pkg::CORDIC_W-1:0]   nsin_val
);

    localparam int TW = mlo_pkg::TURN_W;

    logic signed [mlo_pkg::CORDIC_W-1:0] x_reg, y_reg;
    logic signed [TW-1:0]                z_reg;
    logic [1:0]                          quad_reg;

    logic [TW-1:0]                       biased;
    logic [1:0]                          quad;
    logic signed [mlo_pkg::CORDIC_W-1:0] xs, ys;
    logic signed [TW-1:0]                step_atan;

    assign biased    = angle + (TW'(1) << (TW - 3));
    assign quad      = biased[TW-1:TW-2];
    assign xs        = x_reg >>> iter;
    assign ys        = y_reg >>> iter;
    assign step_atan = mlo_pkg::atan_turn(iter);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quad_reg <= quad;
            z_reg    <= signed'(angle - {quad, {(TW-2){1'b0}}});
            x_reg    <= mlo_pkg::CORDIC_GAIN;
            y_reg    <= '0;
        end
        else if (advance)
        begin
            if (!z_reg[TW-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - step_atan;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + step_atan;
            end
        end
    end

    // rotate the result back by the quadrant; the negated sine comes along
    always_comb
    begin
        unique case (quad_reg)
            2'd0:
            begin
                cos_val  = x_reg;
                sin_val  = y_reg;
                nsin_val = -y_reg;
            end
            2'd1:
            begin
                cos_val  = -y_reg;
                sin_val  = x_reg;
                nsin_val = -x_reg;
            end
            2'd2:
            begin
                cos_val  = -x_reg;
                sin_val  = -y_reg;
                nsin_val = y_reg;
            end
            default:
            begin
                cos_val  = y_reg;
                sin_val  = -x_reg;
                nsin_val = x_reg;
            end
        endcase
    end

endmodule

// ===== hdl/mlo_back.sv =====
// ---------------------------------------------------------------------------
// mlo_back: half-angle trigonometry and quaternion assembly
// Runs yaw and pitch CORDIC lanes side by side, forms the four products on
// one shared multiplier and holds the result in the output register.
// ---------------------------------------------------------------------------
module mlo_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  mlo_pkg::angle_pair_t              head,
    input  mlo_pkg::queue_stat_t              q_stat,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [6*mlo_pkg::OUT_W-1:0]       m_tdata
);

    localparam int AB    = mlo_pkg::ANGLE_BITS;
    localparam int CW    = mlo_pkg::CORDIC_W;
    localparam int PW    = mlo_pkg::PROD_W;
    localparam int OW    = mlo_pkg::OUT_W;
    localparam int TW    = mlo_pkg::TURN_W;
    localparam int CNT_W = 3;
    localparam logic [mlo_pkg::ITER_W-1:0] LAST_ITER = mlo_pkg::ITER_W'(mlo_pkg::CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(4);

    typedef enum logic [3:0]
    {
        B_IDLE = 4'b0001,
        B_ROT  = 4'b0010,
        B_MUL  = 4'b0100,
        B_OUT  = 4'b1000
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [mlo_pkg::ITER_W-1:0] iter_reg;
    logic [CNT_W-1:0]           cnt_reg;
    mlo_pkg::angle_pair_t       pair_reg;
    logic signed [PW-1:0]       prod_reg;
    logic signed [OW-1:0]       quat_reg [4];
    logic                       m_tvalid_reg;
    logic [6*OW-1:0]            m_tdata_reg;

    logic [TW-1:0]              yaw_turn, pitch_turn;
    logic signed [CW-1:0]       cy, sy, nsy, cp, sp, unused_nsp;
    logic signed [CW-1:0]       op_a, op_b;
    logic signed [PW-1:0]       rnd_sum, shifted;
    logic signed [OW-1:0]       rounded;
    logic [1:0]                 slot;
    logic                       out_free;

    // half angle: read the angle in units of twice a full turn
    assign yaw_turn   = {1'b0, head.yaw, {(TW-1-AB){1'b0}}};
    assign pitch_turn = {head.pitch[AB-1], head.pitch, {(TW-1-AB){1'b0}}};

    assign pop      = (state_reg == B_IDLE) && !q_stat.empty;
    assign out_free = !m_tvalid_reg || m_tready;

    mlo_cordic u_cordic_yaw
    (
        .clk      (clk),
        .load     (pop),
        .advance  (state_reg == B_ROT),
        .iter     (iter_reg),
        .angle    (yaw_turn),
        .cos_val  (cy),
        .sin_val  (sy),
        .nsin_val (nsy)
    );

    mlo_cordic u_cordic_pitch
    (
        .clk      (clk),
        .load     (pop),
        .advance  (state_reg == B_ROT),
        .iter     (iter_reg),
        .angle    (pitch_turn),
        .cos_val  (cp),
        .sin_val  (sp),
        .nsin_val (unused_nsp)
    );

    // w = cy*cp, x = cy*sp, y = sy*cp, z = -sy*sp
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                op_a = cy;
                op_b = cp;
            end
            2'd1:
            begin
                op_a = cy;
                op_b = sp;
            end
            2'd2:
            begin
                op_a = sy;
                op_b = cp;
            end
            default:
            begin
                op_a = nsy;
                op_b = sp;
            end
        endcase
    end

    always_comb
    begin
        rnd_sum = prod_reg + mlo_pkg::ROUND_HALF;
        shifted = rnd_sum >>> mlo_pkg::QSHIFT;
        if (shifted > mlo_pkg::Q_MAX)
        begin
            rounded = mlo_pkg::Q_MAX[OW-1:0];
        end
        else if (shifted < mlo_pkg::Q_MIN)
        begin
            rounded = mlo_pkg::Q_MIN[OW-1:0];
        end
        else
        begin
            rounded = shifted[OW-1:0];
        end
    end

    assign slot = cnt_reg[1:0] - 2'd1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    state_next = B_ROT;
                end
            end
            B_ROT:
            begin
                if (iter_reg == LAST_ITER)
                begin
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            iter_reg     <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                iter_reg <= '0;
            end
            else if (state_reg == B_ROT)
            begin
                iter_reg <= iter_reg + mlo_pkg::ITER_W'(1);
            end
            if (state_reg == B_MUL)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else
            begin
                cnt_reg <= '0;
            end
            if (state_reg == B_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pair_reg <= head;
        end
        if (state_reg == B_MUL)
        begin
            if (cnt_reg != LAST_CNT)
            begin
                prod_reg <= op_a * op_b;
            end
            if (cnt_reg != '0)
            begin
                quat_reg[slot] <= rounded;
            end
        end
        if (state_reg == B_OUT && out_free)
        begin
            m_tdata_reg <= {OW'(pair_reg.pitch), OW'(pair_reg.yaw),
                            quat_reg[3], quat_reg[2], quat_reg[1], quat_reg[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/mouse_look_orientation_quaternion.sv =====
// Throughput is set by the 30-step CORDIC loop in the back end plus quaternion
// products on its single shared multiplier; the back end takes a new angle pair
// only after the last result is in the output register. The front end takes a
// new delta after its multiply and update states, while the queue has room.
// Reset (rst_n low, asynchronous): yaw and pitch return to zero, sensitivity to
// 256 (1.0 angle unit per count), queue and output register empty.
// ---------------------------------------------------------------------------
// mouse_look_orientation_quaternion: mouse-look head orientation
// Accumulates yaw and pitch from mouse deltas and emits the head quaternion.
// ---------------------------------------------------------------------------
module mouse_look_orientation_quaternion
#(
    parameter int QUEUE_DEPTH = mlo_pkg::QUEUE_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mlo_pkg::SENS_W-1:0]      cfg_wr_data,   // sensitivity
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [2*mlo_pkg::DELTA_W-1:0]   s_tdata,       // delta_horizontal, delta_vertical
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [6*mlo_pkg::OUT_W-1:0]     m_tdata        // quat_w, quat_x, quat_y, quat_z,
                                                           // yaw_out, pitch_out
);

    mlo_pkg::angle_pair_t push_data, head;
    mlo_pkg::queue_stat_t q_stat;
    logic                 push, pop;

    mlo_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .push        (push),
        .push_data   (push_data),
        .q_stat      (q_stat)
    );

    mlo_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    mlo_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== hdl/mlo_checker.sv =====
// ---------------------------------------------------------------------------
// mlo_checker: port-level checks for the mouse-look orientation block
// Watches the stream ports over time; bound to the top level.
// ---------------------------------------------------------------------------
module mlo_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [6*mlo_pkg::OUT_W-1:0]     m_tdata
);

    logic signed [mlo_pkg::OUT_W-1:0] pitch_field;
    assign pitch_field = m_tdata[6*mlo_pkg::OUT_W-1:5*mlo_pkg::OUT_W];

    // hold a stalled result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

    // the front end never accepts two delta transactions back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on consecutive cycles");

    // pitch stays within plus or minus a quarter turn
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pitch_field <= 16'sd16384) && (pitch_field >= -16'sd16384))
    else $error("pitch out of range");

    // every offered result carries fully known fields
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !$isunknown(m_tdata))
    else $error("unknown result data");

endmodule

bind mouse_look_orientation_quaternion mlo_checker u_mlo_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
